// ===== rtl/core/ddpc_pkg.sv =====
// Shared constants, types and helpers for the digit-dominated prefix counter.
`default_nettype none
package ddpc_pkg;
	localparam int MAX_DIGITS_DEF = 64;
	localparam int DIGIT_W = 8;
	localparam int DATA_W = 64;
	localparam logic [7:0] BASE_RESET = 8'd2;
	localparam logic [0:0] REG_DIGIT_BASE = 1'b0;

	typedef struct packed {
		logic load;      // capture operands, start division of both
		logic div_step;  // one restoring division step on both
		logic div_done;  // store digits of the current position
		logic prod_step; // multiply running product by (m digit + 1)
		logic walk_acc;  // accumulate at walk position
		logic finish;    // final add of one if still tight
		logic zero_out;  // negative limit: result is zero
	} ddpc_cmd_t;

	typedef struct packed {
		logic div_last;  // last bit step of the division
		logic split_end; // both quotients zero or digit limit reached
		logic prod_end;  // all lower products written
		logic walk_end;  // walk reached position zero or stopped
	} ddpc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/digit_dominated_prefix_count_core.sv =====
// Top level of the digit-dominated prefix counter.
// A request splits m and y into digits together in the bit-serial divider loop, builds
// the lower products, walks the digits from the top and ends with a final add of one.
// Only one request is taken at a time; the input stalls until its count has been taken.
// A negative limit presents a count of zero in the cycle after it is accepted.
// Reset (arst_n low) idles the controller and sets the base register to two.
`default_nettype none
module digit_dominated_prefix_count_core import ddpc_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] mask_value,
	input  wire logic [63:0] upper_limit,
	input  wire logic        limit_negative,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      count
);
	logic [7:0] base_q;
	ddpc_cmd_t  cmd;
	ddpc_sts_t  sts;

	// The register file holds only the base; a write lands on the access cycle.
	assign pready = 1'b1;
	assign prdata = (paddr[1] == REG_DIGIT_BASE) ? {24'd0, base_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (psel && penable && pwrite && paddr[1] == REG_DIGIT_BASE) begin
			base_q <= pwdata[7:0];
		end
	end

	ddpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.limit_negative(limit_negative), .out_valid(out_valid),
		.out_stall(out_stall), .sts(sts), .cmd(cmd));

	ddpc_dp #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .base(base_q), .mask_value(mask_value),
		.upper_limit(upper_limit), .cmd(cmd), .sts(sts), .count(count));
endmodule
`default_nettype wire

// ===== rtl/core/ddpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ddpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/ddpc_ctrl.sv =====
// Control state machine that sequences split, product and walk phases.
`default_nettype none
module ddpc_ctrl import ddpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic limit_negative,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire ddpc_sts_t sts,
	output ddpc_cmd_t cmd
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_DIV   = 8'b00000010,
		ST_PRD   = 8'b00000100,
		ST_PROD  = 8'b00001000,
		ST_WRD   = 8'b00010000,
		ST_WACC  = 8'b00100000,
		ST_FIN   = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic   in_acc;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (limit_negative) begin
						cmd.zero_out = 1'b1;
						state_d = ST_OUT;
					end else begin
						cmd.load = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.div_done = 1'b1;
					if (sts.split_end) begin
						state_d = ST_PRD;
					end
				end
			end
			// The mask digit of the current position is read here.
			ST_PRD: begin
				state_d = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod_step = 1'b1;
				state_d = sts.prod_end ? ST_WRD : ST_PRD;
			end
			ST_WRD: begin
				state_d = ST_WACC;
			end
			ST_WACC: begin
				cmd.walk_acc = 1'b1;
				state_d = sts.walk_end ? ST_FIN : ST_WRD;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/ddpc_dp.sv =====
// Datapath: bit-serial digit split, product build and digit walk.
`default_nettype none
module ddpc_dp import ddpc_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  base,
	input  wire logic [63:0] mask_value,
	input  wire logic [63:0] upper_limit,
	input  wire ddpc_cmd_t   cmd,
	output ddpc_sts_t        sts,
	output logic [63:0]      count
);
	localparam int IW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	logic [7:0]  b_q;
	logic [63:0] mq_q, yq_q;       // quotients being built
	logic [63:0] mdiv_q, ydiv_q;   // dividends shifting out
	logic [7:0]  mrem_q, yrem_q;
	logic [5:0]  bit_q;
	logic [CW-1:0] n_q, len_q;
	logic [CW-1:0] pos_q;
	logic [63:0] prod_q, sum_q;
	logic        tight_q;
	logic [7:0]  md_rd, yd_rd;
	logic [63:0] lp_rd;

	logic [8:0]  mtr, ytr;
	logic [7:0]  mrem_n, yrem_n;
	logic        mqb, yqb;
	logic [63:0] mq_n, yq_n;
	logic [CW-1:0] n_n;

	// One restoring division step for each operand; remainder stays below base.
	assign mtr = {mrem_q, mdiv_q[63]} - {1'b0, b_q};
	assign ytr = {yrem_q, ydiv_q[63]} - {1'b0, b_q};
	assign mqb = !mtr[8];
	assign yqb = !ytr[8];
	assign mrem_n = mqb ? mtr[7:0] : {mrem_q[6:0], mdiv_q[63]};
	assign yrem_n = yqb ? ytr[7:0] : {yrem_q[6:0], ydiv_q[63]};
	assign mq_n = {mq_q[62:0], mqb};
	assign yq_n = {yq_q[62:0], yqb};
	assign n_n = n_q + CW'(1);

	assign sts.div_last = (bit_q == 6'd63);
	assign sts.split_end = ((mq_n == '0) && (yq_n == '0)) || (n_n == CW'(MAX_DIGITS));
	assign sts.prod_end = (pos_q + CW'(1) == len_q);
	assign sts.walk_end = (pos_q == '0) || (yd_rd > md_rd);

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [7:0]    md_w, yd_w;

	// During the split the digit of the operand whose quotient hit zero earlier
	// is zero, which matches a zero remainder of a zero dividend.
	assign we = cmd.div_done;
	assign waddr = n_q[IW-1:0];
	assign md_w = mrem_n;
	assign yd_w = yrem_n;
	assign raddr = pos_q[IW-1:0];

	ddpc_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_mram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(md_w), .raddr(raddr), .rdata(md_rd));
	ddpc_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_yram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(yd_w), .raddr(raddr), .rdata(yd_rd));
	ddpc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIGITS)) u_pram (
		.clk(clk), .we(cmd.prod_step), .waddr(raddr), .wdata(prod_q),
		.raddr(raddr), .rdata(lp_rd));

	logic [7:0]  ch;
	logic [8:0]  mp1;
	assign mp1 = {1'b0, md_rd} + 9'd1;
	assign ch = ({1'b0, yd_rd} < mp1) ? yd_rd : mp1[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			tight_q <= 1'b1;
			bit_q <= '0;
			n_q <= '0;
		end else begin
			if (cmd.load) begin
				b_q <= (base < 8'd2) ? 8'd2 : base;
				mdiv_q <= mask_value;
				ydiv_q <= upper_limit;
				mrem_q <= '0;
				yrem_q <= '0;
				mq_q <= '0;
				yq_q <= '0;
				bit_q <= '0;
				n_q <= '0;
			end
			if (cmd.div_step) begin
				bit_q <= bit_q + 6'd1;
				if (cmd.div_done) begin
					mdiv_q <= mq_n;
					ydiv_q <= yq_n;
					mq_q <= '0;
					yq_q <= '0;
					mrem_q <= '0;
					yrem_q <= '0;
					n_q <= n_n;
					if (sts.split_end) begin
						len_q <= n_n;
						pos_q <= '0;
						prod_q <= 64'd1;
					end
				end else begin
					mdiv_q <= {mdiv_q[62:0], 1'b0};
					ydiv_q <= {ydiv_q[62:0], 1'b0};
					mq_q <= mq_n;
					yq_q <= yq_n;
					mrem_q <= mrem_n;
					yrem_q <= yrem_n;
				end
			end
			if (cmd.prod_step) begin
				// The mask digit of this position was read in the cycle before.
				prod_q <= prod_q * {56'd0, mp1[7:0]} + (mp1[8] ? prod_q << 8 : 64'd0);
				pos_q <= sts.prod_end ? len_q - CW'(1) : pos_q + CW'(1);
				sum_q <= '0;
				tight_q <= 1'b1;
			end
			if (cmd.walk_acc) begin
				sum_q <= sum_q + {56'd0, ch} * lp_rd;
				if (yd_rd > md_rd) begin
					tight_q <= 1'b0;
				end
				if (!sts.walk_end) begin
					pos_q <= pos_q - CW'(1);
				end
			end
			if (cmd.finish && tight_q) begin
				sum_q <= sum_q + 64'd1;
			end
			if (cmd.zero_out) begin
				sum_q <= '0;
			end
		end
	end

	assign count = sum_q;
endmodule
`default_nettype wire

// ===== rtl/core/ddpc_chk.sv =====
// Port-level checker for the counter, bound to the top level.
`default_nettype none
module ddpc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        limit_negative,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] count
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && limit_negative) |=> (out_valid && count == 64'd0))
		else $error("negative limit not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(count)))
		else $error("result dropped");
endmodule
bind digit_dominated_prefix_count_core ddpc_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.limit_negative(limit_negative), .out_valid(out_valid),
	.out_stall(out_stall), .count(count));
`default_nettype wire

// ===== dv/digit_dominated_prefix_count_core_test.sv =====
// Self-checking testbench for the digit-dominated prefix counter core.
`timescale 1ns / 100ps
`default_nettype none
module digit_dominated_prefix_count_core_test import ddpc_pkg::*;;

	// Request items waiting for the driver, and counts waiting for the monitor.
	typedef struct {
		logic [63:0] mask;
		logic [63:0] limit;
		logic        neg;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] mask_value, upper_limit;
	logic        limit_negative;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] count;

	request_t    pending_requests[$];
	logic [63:0] expected_counts[$];
	logic [7:0]  base_setting;
	int          mismatches;
	int          counts_checked;
	int          requests_sent;
	longint      cycle_count;

	digit_dominated_prefix_count_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.mask_value(mask_value), .upper_limit(upper_limit),
		.limit_negative(limit_negative),
		.out_valid(out_valid), .out_stall(out_stall), .count(count)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// The count computed digit by digit, the same walk the core performs. The
	// digit arrays are local, so nothing unwritten is ever looked at.
	function automatic logic [63:0] dominated_count(logic [63:0] m, logic [63:0] y,
			logic neg, logic [7:0] base_reg);
		logic [63:0] b;
		logic [7:0]  md[64];
		logic [7:0]  yd[64];
		logic [63:0] low_prod[64];
		logic [63:0] prod, sum, mi, yi, pick, v;
		int          nm, ny, len, i;
		bit          tight;
		if (neg)
			return 64'd0;
		b = (base_reg < 8'd2) ? 64'd2 : {56'd0, base_reg};
		for (i = 0; i < 64; i++) begin
			md[i] = 8'd0;
			yd[i] = 8'd0;
		end
		v = m;
		nm = 0;
		do begin
			md[nm] = 8'(v % b);
			nm++;
			v = v / b;
		end while (v != 0 && nm < 64);
		v = y;
		ny = 0;
		do begin
			yd[ny] = 8'(v % b);
			ny++;
			v = v / b;
		end while (v != 0 && ny < 64);
		len = (nm > ny) ? nm : ny;
		prod = 64'd1;
		for (i = 0; i < len; i++) begin
			low_prod[i] = prod;
			prod = prod * ({56'd0, md[i]} + 64'd1);
		end
		sum = 64'd0;
		tight = 1;
		for (i = len - 1; i >= 0; i--) begin
			yi = {56'd0, yd[i]};
			mi = {56'd0, md[i]};
			pick = (yi < mi + 64'd1) ? yi : mi + 64'd1;
			sum = sum + pick * low_prod[i];
			if (yi > mi) begin
				tight = 0;
				break;
			end
		end
		if (tight)
			sum = sum + 64'd1;
		return sum;
	endfunction

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Acceptance is judged from the stall value sampled at the rising edge.
	logic in_stall_seen;
	initial in_stall_seen = 1'b1;
	always @(posedge clk)
		in_stall_seen <= in_stall;

	// Driver: presents the oldest pending request and predicts its count the
	// moment it is accepted. Inputs only change on the falling edge.
	int driver_gap;
	initial begin
		in_valid = 1'b0;
		mask_value = '0;
		upper_limit = '0;
		limit_negative = 1'b0;
		driver_gap = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_seen) begin
				requests_sent++;
				expected_counts.insert(expected_counts.size(),
					dominated_count(mask_value, upper_limit, limit_negative,
					base_setting));
				void'(pending_requests.pop_front());
				driver_gap = pick_gap();
				in_valid <= 1'b0;
			end else if (!in_valid) begin
				if (driver_gap > 0) begin
					driver_gap--;
				end else if (pending_requests.size() > 0) begin
					mask_value <= pending_requests[0].mask;
					upper_limit <= pending_requests[0].limit;
					limit_negative <= pending_requests[0].neg;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// The receive side stalls at random, in short and occasionally long runs.
	int stall_left;
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
	end
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
			out_stall <= (stall_left > 0);
		end
	end

	// Monitor: every count accepted at a rising edge is checked against the
	// oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected count %h with no request waiting", count);
			end else begin
				if (count !== expected_counts[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("count mismatch: expected %h, got %h",
							expected_counts[0], count);
				end
				counts_checked++;
				void'(expected_counts.pop_front());
			end
		end
	end

	// Timeout: a bound for all 132 items at base two plus stalls, many times over.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 64'd3000000) begin
			$display("run timed out with %0d counts outstanding", expected_counts.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One APB write: a setup phase and then an access phase.
	task automatic write_base(logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_DIGIT_BASE, 1'b0} << 1;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		base_setting = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every request was taken and every count arrived, then lets
	// the core settle before the base register may change.
	task automatic drain();
		while (pending_requests.size() > 0 || in_valid || expected_counts.size() > 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	task automatic add_request(logic [63:0] m, logic [63:0] y, logic neg);
		request_t r;
		r.mask = m;
		r.limit = y;
		r.neg = neg;
		pending_requests.insert(pending_requests.size(), r);
	endtask

	// Random request: mostly well-formed positive limits with varied magnitudes,
	// with a few negative ones and a few related m and y pairs.
	task automatic add_random_request();
		logic [63:0] m, y;
		int          sel;
		m = rand64() >> $urandom_range(0, 63);
		y = rand64() >> $urandom_range(0, 63);
		sel = $urandom_range(0, 9);
		if (sel == 0)
			y = m;
		else if (sel == 1)
			y = m ^ (64'd1 << $urandom_range(0, 63));
		else if (sel == 2)
			m = 64'hFFFF_FFFF_FFFF_FFFF;
		add_request(m, y, ($urandom_range(0, 9) == 0));
	endtask

	logic [7:0] base_list[8];
	int         phase, k;
	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		base_setting = BASE_RESET;
		mismatches = 0;
		counts_checked = 0;
		requests_sent = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset base of two: zeros, extremes, the
		// negative limit, and the case where the count is two to the 64th.
		add_request(64'd0, 64'd0, 1'b0);
		add_request(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0);
		add_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		add_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
		add_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		add_request(64'd5, 64'd5, 1'b0);
		add_request(64'd12, 64'd100, 1'b1);
		drain();

		// Base of zero and one both behave as two; then the extremes and some
		// in-between radixes, each with random requests.
		base_list = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd10, 8'd16, 8'd254, 8'd2};
		for (phase = 0; phase < 8; phase++) begin
			write_base(base_list[phase]);
			if (phase == 2) begin
				add_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
				add_request(64'd254, 64'd255, 1'b0);
				add_request(64'd0, 64'd254, 1'b0);
			end
			for (k = 0; k < 15; k++)
				add_random_request();
			drain();
		end

		$display("%0d requests over nine base settings (0, 1, 2, 3, 10, 16, 254, 255),",
			requests_sent);
		$display("%0d counts checked, %0d mismatches.", counts_checked, mismatches);
		if (mismatches == 0 && expected_counts.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
